/* rtl/tsr_pkg.sv */
`default_nettype none
package tsr_pkg;

  localparam int CW            = 20;          // coordinate bits, 1/16 pixel
  localparam int TW            = 32;          // timestamp bits
  localparam int RW            = 16;          // config register bits
  localparam int DEF_FINGERS   = 2;
  localparam int DW            = CW + 1;      // coordinate difference
  localparam int PW            = DW + TW;     // product of difference and time
  localparam int SW            = PW + 2;      // base plus signed quotient

  localparam logic [RW-1:0] RST_LATENCY     = 16'd5000;
  localparam logic [RW-1:0] RST_MIN_GAP     = 16'd2000;
  localparam logic [RW-1:0] RST_MAX_PREDICT = 16'd8000;

  typedef enum logic [1:0] {
    CFG_LATENCY     = 2'd0,
    CFG_MIN_GAP     = 2'd1,
    CFG_MAX_PREDICT = 2'd2
  } cfg_reg_t;

  localparam logic [1:0] KIND_PASS   = 2'd0;
  localparam logic [1:0] KIND_NEWEST = 2'd1;
  localparam logic [1:0] KIND_INTERP = 2'd2;
  localparam logic [1:0] KIND_EXTRAP = 2'd3;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_PREP,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 cmd;
    logic [3:0]           finger_id;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic [TW-1:0]        time_us;
    logic [3:0]           touches_down;
  } in_t;

  typedef struct packed {
    logic [3:0]           out_finger;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic [TW-1:0]        out_time;
    logic [1:0]           kind;
    logic                 last;
  } out_t;

endpackage
`default_nettype wire

/* rtl/tsr_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle. Divisor must be below 2^(DVW-1).
module tsr_div import tsr_pkg::*; #(
  parameter int NW  = PW,
  parameter int DVW = TW
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [NW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                done,
  output logic [NW-1:0]       quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   quo_r;
  logic [DVW-1:0]  rem_r;
  logic [DVW-1:0]  dvs_r;
  logic [DVW-1:0]  trial;
  logic            ge;

  assign trial = {rem_r[DVW-2:0], quo_r[NW-1]};
  assign ge    = trial >= dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? (trial - dvs_r) : trial;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

/* rtl/touch_sample_resampler.sv */
`default_nettype none
// Touch sample resampler.
// Move beat: passthrough result appears the cycle after the beat is taken.
// Tick beat: each pending finger is resampled with the bit-serial divider,
//   run once for x and once for y; a finger with an unusable gap is sent out
//   unchanged as its newest sample.
// One beat at a time; input stalls until the sequencer is back in idle and the output slot is free.
// Reset (rst_n low, synchronous): inactive, queues empty, registers to defaults.
module touch_sample_resampler import tsr_pkg::*; #(
  parameter int TRACKED_FINGERS = DEF_FINGERS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_t            out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [RW-1:0] cfg_data
);

  localparam int TF  = TRACKED_FINGERS;
  localparam int FIW = (TF > 1) ? $clog2(TF) : 1;

  // configuration
  logic [RW-1:0] lat_r, min_gap_r, max_pred_r;

  // per-finger queue: older and newest sample
  logic signed [CW-1:0] ox_r [TF];
  logic signed [CW-1:0] oy_r [TF];
  logic signed [CW-1:0] nx_r [TF];
  logic signed [CW-1:0] ny_r [TF];
  logic [TW-1:0]        ot_r [TF];
  logic [TW-1:0]        nt_r [TF];
  logic [1:0]           cnt_r [TF];
  logic [TF-1:0]        pend_r;
  logic                 active_r;

  state_t state_r, state_nxt;

  // tick context and working registers
  logic [TW-1:0]        tgt_r;       // tick time minus latency
  logic [3:0]           down_r;
  logic [FIW-1:0]       f_r;
  logic [TW-1:0]        gap_r, d_r;
  logic signed [TW-1:0] m_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [CW-1:0] bx_r, by_r;
  logic signed [PW-1:0] prod_r;
  logic                 neg_r;
  logic                 axis_r;      // 0 x, 1 y
  logic signed [CW-1:0] res_x_r, res_y_r;
  logic [1:0]           kind_r;

  out_t out_r;
  logic out_valid_r;

  // ---- handshake ----
  logic slot_free, in_fire, tracked;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && slot_free);
  assign in_fire   = in_valid && !in_stall;
  assign tracked   = in_data.finger_id < 4'(TF);

  // ---- finger scan ----
  logic [TF-1:0]  qual;
  logic           found;
  logic [FIW-1:0] pick;
  logic           last_w;

  always_comb begin
    pick = '0;
    for (int i = 0; i < TF; i++) begin
      qual[i] = pend_r[i] && (cnt_r[i] != 2'd0);
    end
    for (int i = TF - 1; i >= 0; i--) begin
      if (qual[i]) pick = FIW'(i);
    end
  end
  assign found  = |qual;
  assign last_w = (qual & ~(TF'(1) << f_r)) == '0;

  // ---- setup arithmetic ----
  logic [TW-1:0] gap_w;
  logic          gap_bad;
  assign gap_w   = nt_r[f_r] - ot_r[f_r];
  assign gap_bad = (cnt_r[f_r] < 2'd2) || gap_w[TW-1] || (gap_w == '0) ||
                   (gap_w < TW'(min_gap_r));

  logic [TW-1:0] half_w, s_w;
  always_comb begin
    half_w = {1'b0, gap_r[TW-1:1]};
    s_w    = d_r;
    if (s_w > half_w) s_w = half_w;
    if (s_w > TW'(max_pred_r)) s_w = TW'(max_pred_r);
  end

  // ---- shared multiplier ----
  logic signed [DW-1:0] dsel_w;
  logic signed [PW-1:0] prod_w;
  assign dsel_w = axis_r ? dy_r : dx_r;
  assign prod_w = PW'(dsel_w) * PW'(m_r);

  // ---- divider ----
  logic          div_start, div_done;
  logic [PW-1:0] div_q, div_a;
  assign div_start = (state_r == ST_LOAD);
  // magnitude of the product, taken from its own sign bit on the start cycle
  assign div_a     = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);

  tsr_div #(.NW(PW), .DVW(TW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (gap_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---- accumulate and saturate ----
  logic signed [PW:0]   qs_w;
  logic signed [SW-1:0] sum_w;
  logic signed [CW-1:0] sat_w;
  logic                 ovf_w;
  assign qs_w  = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign sum_w = SW'(axis_r ? by_r : bx_r) + SW'(qs_w);
  assign ovf_w = sum_w[SW-1] ? !(&sum_w[SW-1:CW-1]) : (|sum_w[SW-1:CW-1]);
  assign sat_w = ovf_w ? {sum_w[SW-1], {(CW-1){~sum_w[SW-1]}}} : sum_w[CW-1:0];

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && in_data.cmd == CMD_TICK) state_nxt = ST_SCAN;
      ST_SCAN:  state_nxt = found ? ST_SETUP : ST_IDLE;
      ST_SETUP: state_nxt = gap_bad ? ST_EMIT : ST_PREP;
      ST_PREP:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = axis_r ? ST_EMIT : ST_MUL;
      ST_EMIT:  if (slot_free) state_nxt = ST_SCAN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---- control state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r       <= RST_LATENCY;
      min_gap_r   <= RST_MIN_GAP;
      max_pred_r  <= RST_MAX_PREDICT;
      active_r    <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TF; i++) cnt_r[i] <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LATENCY:     lat_r      <= cfg_data;
          CFG_MIN_GAP:     min_gap_r  <= cfg_data;
          CFG_MAX_PREDICT: max_pred_r <= cfg_data;
          default: ;
        endcase
      end

      // new beat from a passthrough or an emit, else drop once taken
      if ((in_fire && in_data.cmd == CMD_MOVE && (!tracked || !active_r)) ||
          (state_r == ST_EMIT && slot_free))
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;

      if (in_fire && in_data.cmd == CMD_MOVE) begin
        if (!tracked || !active_r) begin
          if (tracked) active_r <= 1'b1;
        end else begin
          pend_r[in_data.finger_id[FIW-1:0]] <= 1'b1;
          if (cnt_r[in_data.finger_id[FIW-1:0]] != 2'd2)
            cnt_r[in_data.finger_id[FIW-1:0]] <= cnt_r[in_data.finger_id[FIW-1:0]] + 2'd1;
        end
      end

      if (state_r == ST_EMIT && slot_free) begin
        pend_r[f_r] <= 1'b0;
      end

      // end of tick: no fingers down and nothing left pending empties everything
      if (state_r == ST_SCAN && !found && down_r == 4'd0 && pend_r == '0) begin
        active_r <= 1'b0;
        for (int i = 0; i < TF; i++) cnt_r[i] <= 2'd0;
      end
    end
  end

  // ---- payload and datapath ----
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (in_data.cmd == CMD_MOVE) begin
        if (!tracked || !active_r) begin
          out_r.out_finger <= in_data.finger_id;
          out_r.out_x      <= in_data.pos_x;
          out_r.out_y      <= in_data.pos_y;
          out_r.out_time   <= in_data.time_us;
          out_r.kind       <= KIND_PASS;
          out_r.last       <= 1'b1;
        end else begin
          nx_r[in_data.finger_id[FIW-1:0]] <= in_data.pos_x;
          ny_r[in_data.finger_id[FIW-1:0]] <= in_data.pos_y;
          nt_r[in_data.finger_id[FIW-1:0]] <= in_data.time_us;
          if (cnt_r[in_data.finger_id[FIW-1:0]] == 2'd0) begin
            ox_r[in_data.finger_id[FIW-1:0]] <= in_data.pos_x;
            oy_r[in_data.finger_id[FIW-1:0]] <= in_data.pos_y;
            ot_r[in_data.finger_id[FIW-1:0]] <= in_data.time_us;
          end else if (cnt_r[in_data.finger_id[FIW-1:0]] == 2'd2) begin
            ox_r[in_data.finger_id[FIW-1:0]] <= nx_r[in_data.finger_id[FIW-1:0]];
            oy_r[in_data.finger_id[FIW-1:0]] <= ny_r[in_data.finger_id[FIW-1:0]];
            ot_r[in_data.finger_id[FIW-1:0]] <= nt_r[in_data.finger_id[FIW-1:0]];
          end
        end
      end else begin
        tgt_r  <= in_data.time_us - TW'(lat_r);
        down_r <= in_data.touches_down;
      end
    end

    case (state_r)
      ST_SCAN: f_r <= pick;
      ST_SETUP: begin
        gap_r   <= gap_w;
        d_r     <= tgt_r - nt_r[f_r];
        dx_r    <= DW'(nx_r[f_r]) - DW'(ox_r[f_r]);
        dy_r    <= DW'(ny_r[f_r]) - DW'(oy_r[f_r]);
        res_x_r <= nx_r[f_r];
        res_y_r <= ny_r[f_r];
        kind_r  <= KIND_NEWEST;
        axis_r  <= 1'b0;
      end
      ST_PREP: begin
        if (d_r[TW-1]) begin
          // sample time falls before the newest sample: interpolate from older
          m_r    <= $signed(gap_r + d_r);
          bx_r   <= ox_r[f_r];
          by_r   <= oy_r[f_r];
          kind_r <= KIND_INTERP;
        end else begin
          m_r    <= $signed(s_w);
          bx_r   <= nx_r[f_r];
          by_r   <= ny_r[f_r];
          kind_r <= KIND_EXTRAP;
        end
      end
      ST_MUL: prod_r <= prod_w;
      ST_LOAD: neg_r <= prod_r[PW-1];
      ST_ACC: begin
        if (axis_r) res_y_r <= sat_w;
        else        res_x_r <= sat_w;
        axis_r <= 1'b1;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_r.out_finger <= 4'(f_r);
          out_r.out_x      <= res_x_r;
          out_r.out_y      <= res_y_r;
          out_r.out_time   <= nt_r[f_r];
          out_r.kind       <= kind_r;
          out_r.last       <= last_w;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---- checks ----
  logic [TF-1:0] nz_w;
  always_comb begin
    for (int i = 0; i < TF; i++) nz_w[i] = cnt_r[i] != 2'd0;
  end

  a_pend_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & ~nz_w) == '0)
    else $error("pending finger with empty queue");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !found && down_r == 4'd0 && pend_r == '0) |=> !active_r)
    else $error("block still active after release tick");

  a_emit_gap_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (gap_r != '0 && !gap_r[TW-1]))
    else $error("divide started with non-positive gap");

endmodule
`default_nettype wire
